// ----- hdl/dctmf_pkg.sv -----
// Package of types and constants for the dual channel trimmed mean filter.
package dctmf_pkg;
   localparam int FIELD_W  = 16;
   localparam int SAMPLE_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_NUM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONV_PERIOD = 2'd2;

   localparam logic [SAMPLE_W-1:0] MAX_SAMPLE = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [FIELD_W-1:0] time_now;
      logic [FIELD_W-1:0] raw_ch1;
      logic [FIELD_W-1:0] raw_ch2;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] temp_ch1_q;
      logic signed [SAMPLE_W-1:0] temp_ch2_q;
      logic signed [SAMPLE_W-1:0] temp_ch1_tenths;
      logic signed [SAMPLE_W-1:0] temp_ch2_tenths;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] raw_ch1;
      logic [FIELD_W-1:0] raw_ch2;
   } job_type;
endpackage

// ----- hdl/dual_channel_trimmed_mean_filter_unit.sv -----
// Dual channel trimmed mean filter: an item whose time is at least conv_period ticks
// past the last queued sample yields one result (40-step gain divide, multiply,
// 8-pass odd-even sort, 6-step sum, tenths); items that are not due are taken while
// the queue has room and give no result. A two-entry queue lets new items in meanwhile.
module dual_channel_trimmed_mean_filter_unit #(
   parameter int KEEP_COUNT  = 4,
   parameter int SPIKE_COUNT = 2,
   parameter int FRAC_BITS   = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dctmf_pkg::req_type     req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dctmf_pkg::rsp_type     rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_idx,
   input  logic [15:0]            csr_wdata
);
   import dctmf_pkg::*;

   logic [15:0] scale_num_ff, scale_den_ff, conv_period_ff;
   logic        job_valid, job_ready;
   job_type     job_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_num_ff   <= 16'd1;
         scale_den_ff   <= 16'd1;
         conv_period_ff <= 16'd100;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_SCALE_NUM:   scale_num_ff   <= csr_wdata;
            CSR_SCALE_DEN:   scale_den_ff   <= csr_wdata;
            CSR_CONV_PERIOD: conv_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   dctmf_front u_front (
      .clock, .reset, .conv_period(conv_period_ff),
      .req_valid, .req_ready, .req_data,
      .job_valid, .job_ready, .job_data
   );

   dctmf_back #(
      .KEEP_COUNT(KEEP_COUNT), .SPIKE_COUNT(SPIKE_COUNT), .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock, .reset, .scale_num(scale_num_ff), .scale_den(scale_den_ff),
      .job_valid, .job_ready, .job_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

// ----- hdl/dctmf_front.sv -----
// Front end: sample time gating and job queue toward the filter engine.
module dctmf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            conv_period,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dctmf_pkg::req_type     req_data,
   output logic                   job_valid,
   input  logic                   job_ready,
   output dctmf_pkg::job_type     job_data
);
   import dctmf_pkg::*;

   localparam int DEPTH = 2;

   logic [FIELD_W-1:0] last_time_ff, last_time_in;
   job_type            q_mem [DEPTH];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               take, push, pop;
   logic [FIELD_W-1:0] delta;

   assign req_ready = (count_ff != 2'(DEPTH));
   assign delta     = req_data.time_now - last_time_ff;
   assign take      = req_valid && req_ready;
   assign push      = take && (delta >= conv_period);
   assign pop       = job_valid && job_ready;
   assign job_valid = (count_ff != 2'd0);
   assign job_data  = q_mem[rd_ptr_ff];
   assign last_time_in = push ? req_data.time_now : last_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         last_time_ff <= last_time_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) q_mem[wr_ptr_ff] <= '{raw_ch1: req_data.raw_ch1, raw_ch2: req_data.raw_ch2};
   end
endmodule

// ----- hdl/dctmf_back.sv -----
// Back end: gain divide, scaling, window update, sort, trimmed mean, tenths.
module dctmf_back #(
   parameter int KEEP_COUNT  = 4,
   parameter int SPIKE_COUNT = 2,
   parameter int FRAC_BITS   = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            scale_num,
   input  logic [15:0]            scale_den,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  dctmf_pkg::job_type     job_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dctmf_pkg::rsp_type     rsp_data
);
   import dctmf_pkg::*;

   localparam int WIN   = KEEP_COUNT + 2 * SPIKE_COUNT;
   localparam int DIVW  = 16 + FRAC_BITS;
   localparam int DCW   = $clog2(DIVW + 1);
   localparam int WIW   = $clog2(WIN + 1);
   localparam int SUMW  = SAMPLE_W + $clog2(KEEP_COUNT + 1);
   localparam int PRODW = DIVW + 16;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_MUL, S_SAT, S_SORT, S_SUM, S_AVG, S_TEN, S_OUT
   } state_type;

   state_type            state_ff;
   logic [DIVW-1:0]      quo_ff;
   logic [15:0]          rem_ff;
   logic [15:0]          den_ff;
   logic [DCW-1:0]       dcnt_ff;
   logic [15:0]          raw1_ff, raw2_ff;
   logic [PRODW-1:0]     prod1_ff, prod2_ff;
   logic [SAMPLE_W-1:0]  win1_ff [WIN];
   logic [SAMPLE_W-1:0]  win2_ff [WIN];
   logic [SAMPLE_W-1:0]  srt1_ff [WIN];
   logic [SAMPLE_W-1:0]  srt2_ff [WIN];
   logic [WIW-1:0]       pass_ff;
   logic [SUMW-1:0]      sum1_ff, sum2_ff;
   logic [SAMPLE_W-1:0]  avg1_ff, avg2_ff;
   logic [SAMPLE_W+3:0]  ten1, ten2;
   logic [16:0]          rem_sh;
   logic [16:0]          rem_sub;
   rsp_type              out_ff;

   assign rem_sh    = {rem_ff, quo_ff[DIVW-1]};
   assign rem_sub   = rem_sh - {1'b0, den_ff};
   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;
   assign ten1 = {4'd0, avg1_ff} * 36'd10;
   assign ten2 = {4'd0, avg2_ff} * 36'd10;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < WIN; i++) begin
            win1_ff[i] <= '0;
            win2_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               raw1_ff  <= job_data.raw_ch1;
               raw2_ff  <= job_data.raw_ch2;
               den_ff   <= (scale_den == 16'd0) ? 16'd1 : scale_den;
               quo_ff   <= {scale_num, {FRAC_BITS{1'b0}}};
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sub[15:0];
                  quo_ff <= {quo_ff[DIVW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[15:0];
                  quo_ff <= {quo_ff[DIVW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DCW'(DIVW - 1)) state_ff <= S_MUL;
            end
            S_MUL: begin
               prod1_ff <= PRODW'(quo_ff) * PRODW'(raw1_ff);
               prod2_ff <= PRODW'(quo_ff) * PRODW'(raw2_ff);
               state_ff <= S_SAT;
            end
            S_SAT: begin
               for (int i = 0; i < WIN - 1; i++) begin
                  win1_ff[i] <= win1_ff[i+1];
                  win2_ff[i] <= win2_ff[i+1];
                  srt1_ff[i] <= win1_ff[i+1];
                  srt2_ff[i] <= win2_ff[i+1];
               end
               win1_ff[WIN-1] <= (prod1_ff > PRODW'(MAX_SAMPLE)) ? MAX_SAMPLE
                                 : prod1_ff[SAMPLE_W-1:0];
               win2_ff[WIN-1] <= (prod2_ff > PRODW'(MAX_SAMPLE)) ? MAX_SAMPLE
                                 : prod2_ff[SAMPLE_W-1:0];
               srt1_ff[WIN-1] <= (prod1_ff > PRODW'(MAX_SAMPLE)) ? MAX_SAMPLE
                                 : prod1_ff[SAMPLE_W-1:0];
               srt2_ff[WIN-1] <= (prod2_ff > PRODW'(MAX_SAMPLE)) ? MAX_SAMPLE
                                 : prod2_ff[SAMPLE_W-1:0];
               pass_ff  <= '0;
               state_ff <= S_SORT;
            end
            S_SORT: begin
               // odd-even transposition, one pass per cycle
               for (int i = 0; i < WIN - 1; i++) begin
                  if ((i % 2) == int'(pass_ff[0])) begin
                     if (srt1_ff[i] > srt1_ff[i+1]) begin
                        srt1_ff[i]   <= srt1_ff[i+1];
                        srt1_ff[i+1] <= srt1_ff[i];
                     end
                     if (srt2_ff[i] > srt2_ff[i+1]) begin
                        srt2_ff[i]   <= srt2_ff[i+1];
                        srt2_ff[i+1] <= srt2_ff[i];
                     end
                  end
               end
               if (pass_ff == WIW'(WIN - 1)) begin
                  pass_ff  <= '0;
                  sum1_ff  <= '0;
                  sum2_ff  <= '0;
                  state_ff <= S_SUM;
               end else begin
                  pass_ff <= pass_ff + 1'b1;
               end
            end
            S_SUM: begin
               for (int i = 0; i < WIN - 1; i++) begin
                  srt1_ff[i] <= srt1_ff[i+1];
                  srt2_ff[i] <= srt2_ff[i+1];
               end
               if (pass_ff >= WIW'(SPIKE_COUNT)) begin
                  sum1_ff <= sum1_ff + SUMW'(srt1_ff[0]);
                  sum2_ff <= sum2_ff + SUMW'(srt2_ff[0]);
               end
               pass_ff <= pass_ff + 1'b1;
               if (pass_ff == WIW'(SPIKE_COUNT + KEEP_COUNT - 1)) state_ff <= S_AVG;
            end
            S_AVG: begin
               avg1_ff  <= SAMPLE_W'(sum1_ff / KEEP_COUNT);
               avg2_ff  <= SAMPLE_W'(sum2_ff / KEEP_COUNT);
               state_ff <= S_TEN;
            end
            S_TEN: begin
               out_ff.temp_ch1_q      <= avg1_ff;
               out_ff.temp_ch2_q      <= avg2_ff;
               out_ff.temp_ch1_tenths <= SAMPLE_W'(ten1 >> FRAC_BITS);
               out_ff.temp_ch2_tenths <= SAMPLE_W'(ten2 >> FRAC_BITS);
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- hdl/dctmf_checker.sv -----
// Port checker for the trimmed mean filter, bound to the top level.
module dctmf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input dctmf_pkg::rsp_type rsp_data
);
   import dctmf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

   a_q_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.temp_ch1_q[31] && !rsp_data.temp_ch2_q[31])
      else $error("negative average");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("back to back results");
endmodule

bind dual_channel_trimmed_mean_filter_unit dctmf_checker u_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
